// ===== rtl/cau_pkg.sv =====
// cau_pkg: shared widths, codes, beat structs and control types for the
// complex arithmetic unit; used by every module in rtl/
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DATA_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_EXPONENT = 63;
  localparam int KIND_W       = 3;
  localparam int EXP_W        = 6;
  localparam int STAT_W       = 2;

  localparam int PROD_W = 2 * DATA_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NUM_W  = PROD_W + FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int LEFT_W = $clog2(MAX_EXPONENT + 1);

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POW = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DIVZ = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]           kind;
    logic signed [DATA_BITS-1:0] a_re;
    logic signed [DATA_BITS-1:0] a_im;
    logic signed [DATA_BITS-1:0] b_re;
    logic signed [DATA_BITS-1:0] b_im;
    logic [EXP_W-1:0]            exponent;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] res_re;
    logic signed [DATA_BITS-1:0] res_im;
    logic [STAT_W-1:0]           status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DRAIN, ST_ROUND, ST_DIV_PREP, ST_DIV, ST_DIV_FIN
  } state_t;

  typedef enum logic [2:0] {
    RES_ADD, RES_SUB, RES_ZERO, RES_DIVZ, RES_A, RES_RND, RES_QUO
  } res_sel_t;

  typedef enum logic [1:0] {SRC_CR, SRC_CI, SRC_YR, SRC_YI} src_t;
  typedef enum logic [1:0] {TGT_RE, TGT_IM, TGT_DEN} tgt_t;

  typedef struct packed {
    src_t src_x;
    src_t src_y;
    tgt_t tgt;
    logic sub;
  } step_t;

  typedef struct packed {
    logic     load;
    logic     y_from_a;
    logic     mul_en;
    step_t    step;
    logic     round;
    logic     div_init;
    logic     div_step;
    logic     finish;
    res_sel_t res_sel;
  } ctl_t;

  typedef struct packed {
    logic b_zero;
  } sts_t;

endpackage

// ===== rtl/cau_datapath.sv =====
// cau_datapath: operand registers, shared 32x32 multiplier with accumulators,
// rounding/saturation and a two-lane restoring divider; depends on cau_pkg
`timescale 1ns / 1ps

module cau_datapath import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  ctl_t ctl,
  output sts_t sts,
  output rsp_t rsp
);

  typedef struct packed {
    logic signed [DATA_BITS-1:0] val;
    logic                        ovf;
  } sat_t;

  localparam logic signed [ACC_W-1:0] MAX_A =
    $signed({{(ACC_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] MIN_A =
    $signed({{(ACC_W-DATA_BITS+1){1'b1}}, {(DATA_BITS-1){1'b0}}});
  localparam logic signed [ACC_W-1:0] HALF =
    (FRAC_BITS > 0) ? (ACC_W'(1) <<< (FRAC_BITS - 1)) : '0;
  localparam logic [NUM_W-1:0] LIM_P = {{(NUM_W-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
  localparam logic [NUM_W-1:0] LIM_N = LIM_P + NUM_W'(1);

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v < MIN_A) begin
      r.val = MIN_A[DATA_BITS-1:0];
      r.ovf = 1'b1;
    end else if (v > MAX_A) begin
      r.val = MAX_A[DATA_BITS-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[DATA_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t sat_quo(input logic [NUM_W-1:0] q, input logic neg);
    sat_t r;
    if (q > (neg ? LIM_N : LIM_P)) begin
      r.val = neg ? MIN_A[DATA_BITS-1:0] : MAX_A[DATA_BITS-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = neg ? -q[DATA_BITS-1:0] : q[DATA_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  logic signed [DATA_BITS-1:0] cur_re, cur_im, y_re, y_im;
  logic signed [PROD_W-1:0]    p;
  logic                        p_vld, p_sub;
  tgt_t                        p_tgt;
  logic signed [ACC_W-1:0]     acc_re, acc_im, acc_den;
  logic                        ovf;
  logic [PROD_W-1:0]           den;
  logic [NUM_W-1:0]            num_re, num_im, q_re, q_im;
  logic [PROD_W:0]             rem_re, rem_im;
  logic                        neg_re, neg_im;

  logic signed [DATA_BITS-1:0] mx, my;
  logic signed [ACC_W-1:0]     p_ext, rnd_re_w, rnd_im_w;
  sat_t                        rnd_re, rnd_im, s_re, s_im, qs_re, qs_im;
  logic [ACC_W-1:0]            mag_re, mag_im;
  logic [PROD_W+1:0]           trial_re, trial_im;
  logic [STAT_W-1:0]           st_sel;

  assign sts.b_zero = (cmd.b_re == '0) && (cmd.b_im == '0);

  always_comb begin
    case (ctl.step.src_x)
      SRC_CR:  mx = cur_re;
      SRC_CI:  mx = cur_im;
      SRC_YR:  mx = y_re;
      default: mx = y_im;
    endcase
    case (ctl.step.src_y)
      SRC_CR:  my = cur_re;
      SRC_CI:  my = cur_im;
      SRC_YR:  my = y_re;
      default: my = y_im;
    endcase
  end

  assign p_ext    = ACC_W'(p);
  assign rnd_re_w = (acc_re + HALF) >>> FRAC_BITS;
  assign rnd_im_w = (acc_im + HALF) >>> FRAC_BITS;
  assign rnd_re   = sat_acc(rnd_re_w);
  assign rnd_im   = sat_acc(rnd_im_w);

  assign mag_re = acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
  assign mag_im = acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);

  // one quotient bit per lane per cycle, both lanes share the denominator
  assign trial_re = {rem_re, num_re[NUM_W-1]} - {2'b00, den};
  assign trial_im = {rem_im, num_im[NUM_W-1]} - {2'b00, den};

  assign qs_re = sat_quo(q_re, neg_re);
  assign qs_im = sat_quo(q_im, neg_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p     <= mx * my;
      p_tgt <= ctl.step.tgt;
      p_sub <= ctl.step.sub;
    end

    if (ctl.load) begin
      cur_re <= cmd.a_re;
      cur_im <= cmd.a_im;
      y_re   <= ctl.y_from_a ? cmd.a_re : cmd.b_re;
      y_im   <= ctl.y_from_a ? cmd.a_im : cmd.b_im;
      ovf    <= 1'b0;
    end else if (ctl.round) begin
      cur_re <= rnd_re.val;
      cur_im <= rnd_im.val;
      ovf    <= ovf | rnd_re.ovf | rnd_im.ovf;
    end

    if (ctl.load || ctl.round) begin
      acc_re  <= '0;
      acc_im  <= '0;
      acc_den <= '0;
    end else if (p_vld) begin
      case (p_tgt)
        TGT_RE:  acc_re  <= p_sub ? acc_re - p_ext : acc_re + p_ext;
        TGT_IM:  acc_im  <= p_sub ? acc_im - p_ext : acc_im + p_ext;
        default: acc_den <= acc_den + p_ext;
      endcase
    end

    if (ctl.div_init) begin
      den    <= acc_den[PROD_W-1:0];
      neg_re <= acc_re[ACC_W-1];
      neg_im <= acc_im[ACC_W-1];
      num_re <= (NUM_W'(mag_re) << FRAC_BITS) + NUM_W'(acc_den[PROD_W-1:1]);
      num_im <= (NUM_W'(mag_im) << FRAC_BITS) + NUM_W'(acc_den[PROD_W-1:1]);
      rem_re <= '0;
      rem_im <= '0;
      q_re   <= '0;
      q_im   <= '0;
    end else if (ctl.div_step) begin
      num_re <= num_re << 1;
      num_im <= num_im << 1;
      if (!trial_re[PROD_W+1]) begin
        rem_re <= trial_re[PROD_W:0];
        q_re   <= {q_re[NUM_W-2:0], 1'b1};
      end else begin
        rem_re <= {rem_re[PROD_W-1:0], num_re[NUM_W-1]};
        q_re   <= {q_re[NUM_W-2:0], 1'b0};
      end
      if (!trial_im[PROD_W+1]) begin
        rem_im <= trial_im[PROD_W:0];
        q_im   <= {q_im[NUM_W-2:0], 1'b1};
      end else begin
        rem_im <= {rem_im[PROD_W-1:0], num_im[NUM_W-1]};
        q_im   <= {q_im[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    s_re   = sat_acc(ACC_W'(cmd.a_re) + ACC_W'(cmd.b_re));
    s_im   = sat_acc(ACC_W'(cmd.a_im) + ACC_W'(cmd.b_im));
    st_sel = STAT_OK;
    if (ctl.res_sel == RES_SUB) begin
      s_re = sat_acc(ACC_W'(cmd.a_re) - ACC_W'(cmd.b_re));
      s_im = sat_acc(ACC_W'(cmd.a_im) - ACC_W'(cmd.b_im));
    end
    if (s_re.ovf || s_im.ovf) begin
      st_sel = STAT_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      case (ctl.res_sel)
        RES_ADD, RES_SUB: begin
          rsp.res_re <= s_re.val;
          rsp.res_im <= s_im.val;
          rsp.status <= st_sel;
        end
        RES_DIVZ: begin
          rsp.res_re <= '0;
          rsp.res_im <= '0;
          rsp.status <= STAT_DIVZ;
        end
        RES_A: begin
          rsp.res_re <= cmd.a_re;
          rsp.res_im <= cmd.a_im;
          rsp.status <= STAT_OK;
        end
        RES_RND: begin
          rsp.res_re <= rnd_re.val;
          rsp.res_im <= rnd_im.val;
          rsp.status <= (ovf || rnd_re.ovf || rnd_im.ovf) ? STAT_OVF : STAT_OK;
        end
        RES_QUO: begin
          rsp.res_re <= qs_re.val;
          rsp.res_im <= qs_im.val;
          rsp.status <= (qs_re.ovf || qs_im.ovf) ? STAT_OVF : STAT_OK;
        end
        default: begin
          rsp.res_re <= '0;
          rsp.res_im <= '0;
          rsp.status <= STAT_OK;
        end
      endcase
    end
  end

endmodule

// ===== rtl/cau_controller.sv =====
// cau_controller: sequencer that walks the multiply steps, rounding passes
// and divider iterations for one beat; depends on cau_pkg
`timescale 1ns / 1ps

module cau_controller import cau_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  logic [EXP_W-1:0]  exponent,
  input  sts_t              sts,
  output ctl_t              ctl,
  output logic              busy,
  output logic              done
);

  state_t            state, state_next;
  logic [2:0]        step_idx, step_idx_next;
  logic              is_div, is_div_next;
  logic [LEFT_W-1:0] left, left_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [LEFT_W-1:0] e_eff;

  // multiply/power: (cr*yr - ci*yi, cr*yi + ci*yr)
  // divide: den = yr^2 + yi^2, re = cr*yr + ci*yi, im = ci*yr - cr*yi
  function automatic step_t step_of(input logic dv, input logic [2:0] idx);
    step_t s;
    s = '{src_x: SRC_CR, src_y: SRC_YR, tgt: TGT_RE, sub: 1'b0};
    if (!dv) begin
      case (idx)
        3'd0:    s = '{src_x: SRC_CR, src_y: SRC_YR, tgt: TGT_RE, sub: 1'b0};
        3'd1:    s = '{src_x: SRC_CI, src_y: SRC_YI, tgt: TGT_RE, sub: 1'b1};
        3'd2:    s = '{src_x: SRC_CR, src_y: SRC_YI, tgt: TGT_IM, sub: 1'b0};
        default: s = '{src_x: SRC_CI, src_y: SRC_YR, tgt: TGT_IM, sub: 1'b0};
      endcase
    end else begin
      case (idx)
        3'd0:    s = '{src_x: SRC_YR, src_y: SRC_YR, tgt: TGT_DEN, sub: 1'b0};
        3'd1:    s = '{src_x: SRC_YI, src_y: SRC_YI, tgt: TGT_DEN, sub: 1'b0};
        3'd2:    s = '{src_x: SRC_CR, src_y: SRC_YR, tgt: TGT_RE, sub: 1'b0};
        3'd3:    s = '{src_x: SRC_CI, src_y: SRC_YI, tgt: TGT_RE, sub: 1'b0};
        3'd4:    s = '{src_x: SRC_CI, src_y: SRC_YR, tgt: TGT_IM, sub: 1'b0};
        default: s = '{src_x: SRC_CR, src_y: SRC_YI, tgt: TGT_IM, sub: 1'b1};
      endcase
    end
    return s;
  endfunction

  assign e_eff = (int'(exponent) > MAX_EXPONENT) ? LEFT_W'(MAX_EXPONENT) : LEFT_W'(exponent);
  assign busy  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_idx <= '0;
      is_div   <= 1'b0;
      left     <= '0;
      cnt      <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      step_idx <= step_idx_next;
      is_div   <= is_div_next;
      left     <= left_next;
      cnt      <= cnt_next;
      done     <= ctl.finish;
    end
  end

  always_comb begin
    state_next    = state;
    step_idx_next = step_idx;
    is_div_next   = is_div;
    left_next     = left;
    cnt_next      = cnt;
    ctl           = '0;
    ctl.step      = step_of(is_div, step_idx);
    ctl.res_sel   = RES_ZERO;
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.load      = 1'b1;
          step_idx_next = '0;
          is_div_next   = 1'b0;
          left_next     = LEFT_W'(1);
          case (kind)
            KIND_ADD: begin
              ctl.finish  = 1'b1;
              ctl.res_sel = RES_ADD;
            end
            KIND_SUB: begin
              ctl.finish  = 1'b1;
              ctl.res_sel = RES_SUB;
            end
            KIND_MUL: state_next = ST_MUL;
            KIND_DIV: begin
              if (sts.b_zero) begin
                ctl.finish  = 1'b1;
                ctl.res_sel = RES_DIVZ;
              end else begin
                is_div_next = 1'b1;
                state_next  = ST_MUL;
              end
            end
            KIND_POW: begin
              ctl.y_from_a = 1'b1;
              if (e_eff < LEFT_W'(2)) begin
                ctl.finish  = 1'b1;
                ctl.res_sel = RES_A;
              end else begin
                left_next  = e_eff - LEFT_W'(1);
                state_next = ST_MUL;
              end
            end
            default: begin
              ctl.finish  = 1'b1;
              ctl.res_sel = RES_ZERO;
            end
          endcase
        end
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        if (step_idx == (is_div ? 3'd5 : 3'd3)) begin
          step_idx_next = '0;
          state_next    = ST_DRAIN;
        end else begin
          step_idx_next = step_idx + 3'd1;
        end
      end
      // last product lands in its accumulator here
      ST_DRAIN: state_next = is_div ? ST_DIV_PREP : ST_ROUND;
      ST_ROUND: begin
        ctl.round = 1'b1;
        if (left == LEFT_W'(1)) begin
          ctl.finish  = 1'b1;
          ctl.res_sel = RES_RND;
          state_next  = ST_IDLE;
        end else begin
          left_next  = left - LEFT_W'(1);
          state_next = ST_MUL;
        end
      end
      ST_DIV_PREP: begin
        ctl.div_init = 1'b1;
        cnt_next     = CNT_W'(NUM_W);
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_next     = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          state_next = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        ctl.finish  = 1'b1;
        ctl.res_sel = RES_QUO;
        state_next  = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (step_idx <= (is_div ? 3'd5 : 3'd3)))
    else $error("multiply step index out of range");
  a_add_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == KIND_ADD)) |=> (done && !busy))
    else $error("add did not finish in one cycle");
  a_left_nz: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (left != '0))
    else $error("rounding pass with no multiplies left");
`endif

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// complex arithmetic unit: add, subtract, multiply, divide and power on signed Q16.16 pairs
// add, subtract, unknown kind, divide by zero, exponent 0/1: done in the cycle after accept
// multiply: 4 products; divide: 6 products on one multiplier, then an 81-step divider
// power exponent e: e-1 complex multiplies on one shared 32x32 multiplier
// one beat at a time; start taken when busy is low; rst clears the sequencer and the product-valid flag only
`timescale 1ns / 1ps

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  ctl_t ctl;
  sts_t sts;
  logic busy_int;
  logic take;

  // the controller only sees start when the beat is really accepted
  assign take = start && !busy_int;
  assign busy = busy_int;

  cau_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (take),
    .kind     (cmd.kind),
    .exponent (cmd.exponent),
    .sts      (sts),
    .ctl      (ctl),
    .busy     (busy_int),
    .done     (done)
  );

  cau_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ctl (ctl),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== tb/cau_checker.sv =====
// cau_checker: watches command and response beats of the complex arithmetic unit,
// predicts each response in fixed point and compares; depends on cau_pkg
`timescale 1ns / 1ps

module cau_checker import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  cmd_t     cmd,
  input  logic     done,
  input  rsp_t     rsp,
  output int       fail_count,
  output int       pending,
  output int       rsp_count
);

  rsp_t expected_q[$];

  function automatic logic signed [DATA_BITS-1:0] clamp(input logic signed [191:0] x,
                                                       inout logic ovf);
    logic signed [191:0] maxv;
    logic signed [191:0] minv;
    maxv = (192'sd1 <<< (DATA_BITS - 1)) - 1;
    minv = -(192'sd1 <<< (DATA_BITS - 1));
    if (x > maxv) begin
      ovf = 1'b1;
      return maxv[DATA_BITS-1:0];
    end
    if (x < minv) begin
      ovf = 1'b1;
      return minv[DATA_BITS-1:0];
    end
    return x[DATA_BITS-1:0];
  endfunction

  // round half up, then saturate
  function automatic logic signed [DATA_BITS-1:0] round_sat(input logic signed [191:0] p,
                                                           inout logic ovf);
    logic signed [191:0] r;
    r = p;
    if (FRAC_BITS > 0) r = r + (192'sd1 <<< (FRAC_BITS - 1));
    r = r >>> FRAC_BITS;
    return clamp(r, ovf);
  endfunction

  function automatic logic signed [DATA_BITS-1:0] div_part(input logic signed [191:0] n,
                                                          input logic signed [191:0] d,
                                                          inout logic ovf);
    logic signed [191:0] mag;
    logic signed [191:0] q;
    mag = (n < 0) ? -n : n;
    q = ((mag <<< FRAC_BITS) + (d >>> 1)) / d;
    return clamp((n < 0) ? -q : q, ovf);
  endfunction

  function automatic void cprod(input logic signed [191:0] ar, ai, br, bi,
                                output logic signed [DATA_BITS-1:0] pr, pi,
                                inout logic ovf);
    pr = round_sat(ar * br - ai * bi, ovf);
    pi = round_sat(ar * bi + ai * br, ovf);
  endfunction

  function automatic rsp_t predict_result(input cmd_t c);
    rsp_t r;
    logic ovf;
    logic signed [191:0] ar, ai, br, bi, den;
    logic signed [DATA_BITS-1:0] pr, pi;
    int e;
    ovf = 1'b0;
    ar = c.a_re; ai = c.a_im; br = c.b_re; bi = c.b_im;
    r = '0;
    r.status = STAT_OK;
    case (c.kind)
      KIND_ADD: begin
        r.res_re = clamp(ar + br, ovf);
        r.res_im = clamp(ai + bi, ovf);
      end
      KIND_SUB: begin
        r.res_re = clamp(ar - br, ovf);
        r.res_im = clamp(ai - bi, ovf);
      end
      KIND_MUL: begin
        cprod(ar, ai, br, bi, pr, pi, ovf);
        r.res_re = pr; r.res_im = pi;
      end
      KIND_DIV: begin
        if (br == 0 && bi == 0) begin
          r.status = STAT_DIVZ;
        end else begin
          den = br * br + bi * bi;
          r.res_re = div_part(ar * br + ai * bi, den, ovf);
          r.res_im = div_part(ai * br - ar * bi, den, ovf);
        end
      end
      KIND_POW: begin
        e = (c.exponent > MAX_EXPONENT) ? MAX_EXPONENT : c.exponent;
        r.res_re = c.a_re; r.res_im = c.a_im;
        for (int i = 1; i < e; i++) begin
          cprod(r.res_re, r.res_im, ar, ai, pr, pi, ovf);
          r.res_re = pr; r.res_im = pi;
        end
      end
      default: ;
    endcase
    if (r.status == STAT_OK && ovf) r.status = STAT_OVF;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t exp_r;
    if (rst) begin
      fail_count <= 0;
      rsp_count <= 0;
    end else begin
      // response first: an add or subtract may finish in the same edge a new beat lands
      if (done) begin
        rsp_count <= rsp_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected response re=%h im=%h st=%0d", $time,
                   rsp.res_re, rsp.res_im, rsp.status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (rsp !== exp_r) begin
            $display("%0t: mismatch expected re=%h im=%h st=%0d actual re=%h im=%h st=%0d",
                     $time, exp_r.res_re, exp_r.res_im, exp_r.status,
                     rsp.res_re, rsp.res_im, rsp.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(predict_result(cmd));
    end
  end

  assign pending = expected_q.size();

endmodule

// ===== tb/complex_arithmetic_unit_tb.sv =====
// complex_arithmetic_unit_tb: drives directed and random command beats into the
// complex arithmetic unit and reports the verdict; depends on cau_pkg and cau_checker
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb import cau_pkg::*;;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   rsp_count;
  int   cycles = 0;
  int   idle_pct;
  int   sent;

  localparam int CYCLE_LIMIT = 4000000;

  complex_arithmetic_unit DUT (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .rsp(rsp)
  );

  cau_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
    .rsp_count(rsp_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [DATA_BITS-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return $urandom_range(0, 3) << 16;
      4: return -($urandom_range(0, 3) << 16);
      5, 6: return $signed($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  // hold the beat until the unit takes it, with optional idle cycles first
  task automatic send_cmd(input cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] k, input logic [31:0] ar, ai, br, bi,
                             input logic [5:0] e);
    cmd_t c;
    c.kind = k; c.a_re = ar; c.a_im = ai; c.b_re = br; c.b_im = bi; c.exponent = e;
    send_cmd(c);
  endtask

  initial begin
    cmd_t c;
    int k;
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes, every kind, divide by zero, small and large exponents, unknown kinds
    send_fields(KIND_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_fields(KIND_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_fields(KIND_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, 32'h0000_8000, 0);
    send_fields(KIND_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000, 0);
    send_fields(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 63);
    send_fields(KIND_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0000_8000, 32'h0, 0);
    send_fields(KIND_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 0);
    send_fields(KIND_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 0);
    send_fields(KIND_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0, 0);
    send_fields(KIND_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0);
    send_fields(KIND_POW, 32'h1234_5678, 32'h9abc_def0, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_fields(KIND_POW, 32'h1234_5678, 32'h9abc_def0, 32'h0, 32'h0, 1);
    send_fields(KIND_POW, 32'h0000_f000, 32'h0000_4000, 32'h0, 32'h0, 63);
    send_fields(KIND_POW, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 40);
    send_fields(KIND_POW, 32'h0000_0000, 32'h0001_0000, 32'h0, 32'h0, 2);
    send_fields(3'd5, 32'h1, 32'h2, 32'h3, 32'h4, 6'h2a);
    send_fields(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 6'h3f);
    send_fields(3'd7, 32'h0, 32'h0, 32'h0, 32'h0, 6'h15);

    for (int i = 0; i < 1700; i++) begin
      case ((i * 4) / 1700)
        0: idle_pct = 0;
        1: idle_pct = 47;
        2: idle_pct = 6;
        default: idle_pct = (i % 200 < 100) ? 0 : 47;
      endcase
      k = $urandom_range(0, 19);
      c.kind = (k < 19) ? 3'(k % 5) : 3'($urandom_range(5, 7));
      c.a_re = rand_part(); c.a_im = rand_part();
      c.b_re = rand_part(); c.b_im = rand_part();
      if ($urandom_range(0, 9) == 0) begin
        c.b_re = '0; c.b_im = '0;
      end
      // mostly short powers, a few long ones
      c.exponent = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
      send_cmd(c);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("sent %0d commands over all kinds, extremes and idle mixes; %0d responses checked",
             sent, rsp_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cau_pkg.sv
rtl/cau_datapath.sv
rtl/cau_controller.sv
rtl/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
